>>> rtl/assert_macros.svh
// Assertion helpers, clocked on clk and held off during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds on every cycle out of reset
`define DTT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent on the same edge
`define DTT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent on the following edge
`define DTT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/dtt_pkg.sv
package dtt_pkg;

  localparam int TIMERS   = 32;
  localparam int DUR_BITS = 48;
  localparam int ID_W     = 5;
  localparam int CNT_W    = 6;
  localparam int TIME_W   = 64;

  // request codes
  localparam logic [2:0] REQ_CREATE = 3'd0;
  localparam logic [2:0] REQ_ONCE   = 3'd1;
  localparam logic [2:0] REQ_PER    = 3'd2;
  localparam logic [2:0] REQ_STOP   = 3'd3;
  localparam logic [2:0] REQ_DELETE = 3'd4;
  localparam logic [2:0] REQ_QUERY  = 3'd5;
  localparam logic [2:0] REQ_TICK   = 3'd6;
  localparam logic [2:0] REQ_BAD    = 3'd7;

  // result kinds
  localparam logic [1:0] KIND_ACK  = 2'd0;
  localparam logic [1:0] KIND_FIRE = 2'd1;
  localparam logic [1:0] KIND_IDLE = 2'd2;

  typedef struct packed {
    logic [2:0]          req_type;
    logic [ID_W-1:0]     timer_id;
    logic [DUR_BITS-1:0] duration_us;
  } req_t;

  typedef struct packed {
    logic [1:0]      result_kind;
    logic [ID_W-1:0] handle;
    logic            status;
    logic            is_active;
    logic            last;
  } res_t;

  // classified command handed from front to back
  typedef struct packed {
    logic [2:0]          op;
    logic [ID_W-1:0]     id;
    logic [DUR_BITS-1:0] dur;
  } cmd_t;

endpackage

>>> rtl/dtt_front.sv
module dtt_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  dtt_pkg::req_t item,
  output logic          cmd_valid,
  input  logic          cmd_take,
  output dtt_pkg::cmd_t cmd
);
  import dtt_pkg::*;

  cmd_t       slot [2];
  logic       wp, rp;
  logic [1:0] cnt;
  cmd_t       cls;
  logic       wr, rd;

  // classify: zero period clamps to one
  always_comb begin
    cls.op  = item.req_type;
    cls.id  = item.timer_id;
    cls.dur = item.duration_us;
    if (item.req_type == REQ_PER && item.duration_us == '0) begin
      cls.dur = DUR_BITS'(1);
    end
  end

  assign full      = (cnt == 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = slot[rp];
  assign wr        = push && !full;
  assign rd        = cmd_take && cmd_valid;

  // two-entry command queue
  always_ff @(posedge clk) begin
    if (wr) begin
      slot[wp] <= cls;
    end
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr) wp <= !wp;
      if (rd) rp <= !rp;
      cnt <= cnt + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

>>> rtl/dtt_resq.sv
module dtt_resq (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  dtt_pkg::res_t wdata,
  output logic          qfull,
  output logic          empty,
  input  logic          pop,
  output dtt_pkg::res_t result
);
  import dtt_pkg::*;

  `include "assert_macros.svh"

  res_t       slot [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       rd;

  assign qfull  = (cnt == 2'd2);
  assign empty  = (cnt == 2'd0);
  assign result = slot[rp];
  assign rd     = pop && !empty;

  // two-entry result queue
  always_ff @(posedge clk) begin
    if (wr && !qfull) begin
      slot[wp] <= wdata;
    end
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr && !qfull) wp <= !wp;
      if (rd) rp <= !rp;
      cnt <= cnt + {1'b0, wr && !qfull} - {1'b0, rd};
    end
  end

  `DTT_ALWAYS(a_cnt_range, cnt != 2'd3, "result queue count out of range")
  `DTT_IMPLY(a_no_overrun, wr, !qfull, "beat written into full result queue")

endmodule

>>> rtl/dtt_back.sv
module dtt_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_take,
  input  dtt_pkg::cmd_t cmd_in,
  output logic          res_wr,
  output dtt_pkg::res_t res,
  input  logic          qfull
);
  import dtt_pkg::*;

  `include "assert_macros.svh"

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_DFIND = 3'd2;
  localparam logic [2:0] S_DMOVE = 3'd3;
  localparam logic [2:0] S_DACK  = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;
  localparam logic [2:0] S_FIRE  = 3'd6;
  localparam logic [2:0] S_TEND  = 3'd7;

  logic [2:0]          state;
  cmd_t                cmd;
  logic [TIMERS-1:0]   used, active, periodic, fired;
  logic [DUR_BITS-1:0] period   [TIMERS];
  logic [TIME_W-1:0]   deadline [TIMERS];
  logic [ID_W-1:0]     order    [TIMERS];
  logic [CNT_W-1:0]    live;
  logic [TIME_W-1:0]   now;
  logic [CNT_W-1:0]    p;
  logic [ID_W-1:0]     best;
  logic                best_found;
  logic [TIME_W-1:0]   best_dl;
  logic                pend_v;
  res_t                pend;

  logic [ID_W-1:0]     scan_s, dl_addr, free_s;
  logic                free_ok, valid, cand;
  logic [TIME_W-1:0]   dl_rd;
  logic [TIME_W:0]     start_sum, reload_sum;
  logic [TIME_W-1:0]   start_dl, reload_dl;

  // lowest free slot
  always_comb begin
    free_s  = '0;
    free_ok = 1'b0;
    for (int i = TIMERS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_s  = ID_W'(i);
        free_ok = 1'b1;
      end
    end
  end

  assign valid   = used[cmd.id];
  assign scan_s  = order[p[ID_W-1:0]];
  assign dl_addr = (state == S_FIRE) ? best : scan_s;
  assign dl_rd   = deadline[dl_addr];
  assign cand    = (p < live) && used[scan_s] && active[scan_s] && !fired[scan_s]
                   && (dl_rd <= now)
                   && (!best_found || dl_rd < best_dl);

  // saturating deadline sums
  assign start_sum  = {1'b0, now} + {{(TIME_W+1-DUR_BITS){1'b0}}, cmd.dur};
  assign start_dl   = start_sum[TIME_W] ? '1 : start_sum[TIME_W-1:0];
  assign reload_sum = {1'b0, dl_rd} + {{(TIME_W+1-DUR_BITS){1'b0}}, period[best]};
  assign reload_dl  = reload_sum[TIME_W] ? '1 : reload_sum[TIME_W-1:0];

  // result beat and command take
  always_comb begin
    cmd_take = (state == S_IDLE) && cmd_valid;
    res_wr   = 1'b0;
    res      = '{result_kind: KIND_ACK, handle: cmd.id, status: 1'b0,
                 is_active: 1'b0, last: 1'b1};
    unique case (state)
      S_EXEC: begin
        if (!qfull) begin
          unique case (cmd.op)
            REQ_CREATE: begin
              res_wr       = 1'b1;
              res.handle   = free_ok ? free_s : '0;
              res.status   = !free_ok;
            end
            REQ_ONCE, REQ_PER: begin
              res_wr        = 1'b1;
              res.status    = !valid;
              res.is_active = valid;
            end
            REQ_STOP: begin
              res_wr     = 1'b1;
              res.status = !valid;
            end
            REQ_QUERY: begin
              res_wr        = 1'b1;
              res.status    = !valid;
              res.is_active = valid && active[cmd.id];
            end
            REQ_DELETE: begin
              res_wr     = !valid;
              res.status = 1'b1;
            end
            REQ_TICK: res_wr = 1'b0;
            default: begin
              res_wr     = 1'b1;
              res.status = 1'b1;
            end
          endcase
        end
      end
      S_DACK: res_wr = !qfull;
      S_FIRE: begin
        res_wr = pend_v && !qfull;
        res    = pend;
      end
      S_TEND: begin
        res_wr = !qfull;
        if (pend_v) begin
          res      = pend;
          res.last = 1'b1;
        end else begin
          res = '{result_kind: KIND_IDLE, handle: '0, status: 1'b0,
                  is_active: 1'b0, last: 1'b1};
        end
      end
      default: res_wr = 1'b0;
    endcase
  end

  // table payload
  always_ff @(posedge clk) begin
    if (cmd_take) cmd <= cmd_in;
    if (state == S_EXEC && !qfull && valid
        && (cmd.op == REQ_ONCE || cmd.op == REQ_PER)) begin
      deadline[cmd.id] <= start_dl;
      period[cmd.id]   <= cmd.dur;
    end
    if (state == S_EXEC && !qfull && cmd.op == REQ_CREATE && free_ok) begin
      order[live[ID_W-1:0]] <= free_s;
    end
    if (state == S_DMOVE) begin
      order[p[ID_W-1:0]] <= order[live[ID_W-1:0]];
    end
    if (state == S_SCAN && cand) begin
      best    <= scan_s;
      best_dl <= dl_rd;
    end
    if (state == S_FIRE && !(pend_v && qfull)) begin
      if (periodic[best]) deadline[best] <= reload_dl;
      pend <= '{result_kind: KIND_FIRE, handle: best, status: 1'b0,
                is_active: periodic[best], last: 1'b0};
    end
  end

  // control and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used       <= '0;
      active     <= '0;
      periodic   <= '0;
      fired      <= '0;
      live       <= '0;
      now        <= '0;
      p          <= '0;
      best_found <= 1'b0;
      pend_v     <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (cmd_valid) state <= S_EXEC;
        S_EXEC: begin
          unique case (cmd.op)
            REQ_TICK: begin
              if (now != '1) now <= now + TIME_W'(1);
              fired      <= '0;
              pend_v     <= 1'b0;
              p          <= '0;
              best_found <= 1'b0;
              state      <= S_SCAN;
            end
            REQ_DELETE: begin
              if (valid) begin
                p     <= '0;
                state <= S_DFIND;
              end else if (!qfull) begin
                state <= S_IDLE;
              end
            end
            default: begin
              if (!qfull) begin
                state <= S_IDLE;
                if (cmd.op == REQ_CREATE && free_ok) begin
                  used[free_s]     <= 1'b1;
                  active[free_s]   <= 1'b0;
                  periodic[free_s] <= 1'b0;
                  live             <= live + CNT_W'(1);
                end
                if (valid && (cmd.op == REQ_ONCE || cmd.op == REQ_PER)) begin
                  active[cmd.id]   <= 1'b1;
                  periodic[cmd.id] <= (cmd.op == REQ_PER);
                end
                if (valid && cmd.op == REQ_STOP) active[cmd.id] <= 1'b0;
              end
            end
          endcase
        end
        S_DFIND: begin
          if (scan_s == cmd.id) begin
            live  <= live - CNT_W'(1);
            state <= S_DMOVE;
          end else if (p + CNT_W'(1) >= live) begin
            state <= S_DACK;
          end else begin
            p <= p + CNT_W'(1);
          end
        end
        S_DMOVE: state <= S_DACK;
        S_DACK: begin
          used[cmd.id]     <= 1'b0;
          active[cmd.id]   <= 1'b0;
          periodic[cmd.id] <= 1'b0;
          if (!qfull) state <= S_IDLE;
        end
        S_SCAN: begin
          if (cand) best_found <= 1'b1;
          if (p < live) begin
            p <= p + CNT_W'(1);
          end else begin
            state <= best_found ? S_FIRE : S_TEND;
          end
        end
        S_FIRE: begin
          if (!(pend_v && qfull)) begin
            if (!periodic[best]) active[best] <= 1'b0;
            fired[best] <= 1'b1;
            pend_v      <= 1'b1;
            p           <= '0;
            best_found  <= 1'b0;
            state       <= S_SCAN;
          end
        end
        S_TEND: if (!qfull) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  `DTT_ALWAYS(a_live_cap, live <= CNT_W'(TIMERS), "live count beyond table size")
  `DTT_IMPLY(a_wr_room, res_wr, !qfull, "result beat with no room")
  `DTT_NEXT(a_fire_mark, state == S_FIRE && !(pend_v && qfull),
            fired[best] && pend_v, "fired timer not marked")
  `DTT_IMPLY(a_take_idle, cmd_take, state == S_IDLE, "command taken while busy")

endmodule

>>> rtl/deadline_timer_table.sv
// Table of 32 software timers on a microsecond tick. Requests enter through a
// two-beat queue and results leave through another, so either side may stall.
// A delete does a linear search of the scan-order list of live timers. In a
// tick, every fire is one pass over the scan-order list with one deadline
// compare per cycle, and then the chosen timer is reloaded or retired.
// Each fire gives one result beat; a tick that fires nothing gives one beat
// of kind "nothing fired". The final beat of each request has last set.
module deadline_timer_table (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  dtt_pkg::req_t item,
  output logic          empty,
  input  logic          pop,
  output dtt_pkg::res_t result
);
  import dtt_pkg::*;

  cmd_t cmd;
  res_t res;
  logic cmd_valid, cmd_take, res_wr, qfull;

  dtt_front u_front (
    .clk, .rst, .push, .full, .item,
    .cmd_valid, .cmd_take, .cmd
  );

  dtt_back u_back (
    .clk, .rst, .cmd_valid, .cmd_take, .cmd_in(cmd),
    .res_wr, .res, .qfull
  );

  dtt_resq u_resq (
    .clk, .rst, .wr(res_wr), .wdata(res), .qfull,
    .empty, .pop, .result
  );

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import dtt_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 200;

  logic clk;
  logic rst;
  logic push;
  logic full;
  req_t item;
  logic empty;
  logic pop = 1'b0;
  res_t result;

  deadline_timer_table i_dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // own copy of the timer table
  logic                tmr_used     [TIMERS];
  logic                tmr_active   [TIMERS];
  logic                tmr_periodic [TIMERS];
  logic [DUR_BITS-1:0] tmr_period   [TIMERS];
  logic [TIME_W-1:0]   tmr_deadline [TIMERS];
  logic [ID_W-1:0]     scan_list    [TIMERS];
  int                  live_timers;
  logic [TIME_W-1:0]   usec_now;

  res_t expected_beats[$];
  int   fail_count = 0;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   quiet_cycles = 0;

  function automatic logic [TIME_W-1:0] sat_sum(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

  function automatic res_t mk_res(logic [1:0] k, int h, logic st, logic act, logic lst);
    res_t r;
    r.result_kind = k;
    r.handle      = h[ID_W-1:0];
    r.status      = st;
    r.is_active   = act;
    r.last        = lst;
    return r;
  endfunction

  // work out the beats one request causes and update the table copy
  function automatic void predict_timers(req_t r, ref res_t beats[$]);
    int                  id;
    int                  s;
    int                  best;
    logic                ok;
    logic                fired [TIMERS];
    logic [DUR_BITS-1:0] dur;
    id  = r.timer_id;
    dur = r.duration_us;
    ok  = (id < TIMERS) && tmr_used[id];
    beats.delete();
    case (r.req_type)
      REQ_CREATE: begin
        for (s = 0; s < TIMERS; s++)
          if (!tmr_used[s]) break;
        if (s >= TIMERS || live_timers >= TIMERS) begin
          beats.push_back(mk_res(KIND_ACK, 0, 1'b1, 1'b0, 1'b1));
        end else begin
          tmr_used[s]     = 1'b1;
          tmr_active[s]   = 1'b0;
          tmr_periodic[s] = 1'b0;
          scan_list[live_timers] = s[ID_W-1:0];
          live_timers++;
          beats.push_back(mk_res(KIND_ACK, s, 1'b0, 1'b0, 1'b1));
        end
      end
      REQ_ONCE, REQ_PER, REQ_STOP, REQ_DELETE, REQ_QUERY: begin
        if (!ok) begin
          beats.push_back(mk_res(KIND_ACK, id, 1'b1, 1'b0, 1'b1));
        end else begin
          case (r.req_type)
            REQ_ONCE: begin
              tmr_periodic[id] = 1'b0;
              tmr_period[id]   = '0;
              tmr_deadline[id] = sat_sum(usec_now, TIME_W'(dur));
              tmr_active[id]   = 1'b1;
            end
            REQ_PER: begin
              if (dur == 0) dur = 1;
              tmr_periodic[id] = 1'b1;
              tmr_period[id]   = dur;
              tmr_deadline[id] = sat_sum(usec_now, TIME_W'(dur));
              tmr_active[id]   = 1'b1;
            end
            REQ_STOP: tmr_active[id] = 1'b0;
            REQ_DELETE: begin
              tmr_active[id]   = 1'b0;
              tmr_periodic[id] = 1'b0;
              tmr_used[id]     = 1'b0;
              for (s = 0; s < live_timers; s++) begin
                if (scan_list[s] == id) begin
                  live_timers--;
                  scan_list[s] = scan_list[live_timers];
                  break;
                end
              end
            end
            default: ;
          endcase
          beats.push_back(mk_res(KIND_ACK, id, 1'b0, tmr_active[id], 1'b1));
        end
      end
      REQ_TICK: begin
        foreach (fired[i]) fired[i] = 1'b0;
        if (usec_now != {TIME_W{1'b1}}) usec_now++;
        while (beats.size() < TIMERS) begin
          best = -1;
          for (int p = 0; p < live_timers; p++) begin
            s = scan_list[p];
            if (!tmr_used[s] || !tmr_active[s] || fired[s]) continue;
            if (tmr_deadline[s] > usec_now) continue;
            if (best < 0 || tmr_deadline[s] < tmr_deadline[best]) best = s;
          end
          if (best < 0) break;
          fired[best] = 1'b1;
          if (tmr_periodic[best])
            tmr_deadline[best] = sat_sum(tmr_deadline[best], TIME_W'(tmr_period[best]));
          else
            tmr_active[best] = 1'b0;
          beats.push_back(mk_res(KIND_FIRE, best, 1'b0, tmr_active[best], 1'b0));
        end
        if (beats.size() == 0) beats.push_back(mk_res(KIND_IDLE, 0, 1'b0, 1'b0, 1'b1));
        else beats[beats.size()-1].last = 1'b1;
      end
      default: beats.push_back(mk_res(KIND_ACK, id, 1'b1, 1'b0, 1'b1));
    endcase
  endfunction

  // offer one request beat; typed expectation replaces the predicted one if given
  task automatic send_req(req_t r, bit typed = 1'b0, res_t typed_res = '0);
    res_t beats[$];
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= r;
    do @(posedge clk); while (full);
    predict_timers(r, beats);
    if (typed) expected_beats.push_back(typed_res);
    else foreach (beats[i]) expected_beats.push_back(beats[i]);
  endtask

  function automatic req_t mk_req(logic [2:0] op, int id, logic [DUR_BITS-1:0] dur);
    req_t r;
    r.req_type    = op;
    r.timer_id    = id[ID_W-1:0];
    r.duration_us = dur;
    return r;
  endfunction

  // random request, mostly aimed at live timers
  function automatic req_t rand_req();
    int                  w;
    int                  id;
    logic [2:0]          op;
    logic [DUR_BITS-1:0] dur;
    w = $urandom_range(99);
    if (w < 14) op = REQ_CREATE;
    else if (w < 28) op = REQ_ONCE;
    else if (w < 42) op = REQ_PER;
    else if (w < 50) op = REQ_STOP;
    else if (w < 58) op = REQ_DELETE;
    else if (w < 64) op = REQ_QUERY;
    else if (w < 96) op = REQ_TICK;
    else op = REQ_BAD;
    if (live_timers > 0 && $urandom_range(9) < 8)
      id = scan_list[$urandom_range(live_timers - 1)];
    else
      id = $urandom_range(TIMERS - 1);
    if ($urandom_range(9) == 0) dur = DUR_BITS'({$urandom, $urandom});
    else dur = DUR_BITS'($urandom_range(6));
    return mk_req(op, id, dur);
  endfunction

  // result side: random pop, field checks, watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL deadline_timer_table");
        $finish;
      end
      if (pop && !empty) begin
        if (expected_beats.size() == 0) begin
          $error("result beat with nothing expected: %p", result);
          fail_count++;
        end else begin
          res_t e;
          e = expected_beats.pop_front();
          if (result.result_kind !== e.result_kind) begin
            $error("result_kind expected %0d actual %0d", e.result_kind, result.result_kind);
            fail_count++;
          end
          if (result.handle !== e.handle) begin
            $error("handle expected %0d actual %0d", e.handle, result.handle);
            fail_count++;
          end
          if (result.status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, result.status);
            fail_count++;
          end
          if (result.is_active !== e.is_active) begin
            $error("is_active expected %0d actual %0d", e.is_active, result.is_active);
            fail_count++;
          end
          if (result.last !== e.last) begin
            $error("last expected %0d actual %0d", e.last, result.last);
            fail_count++;
          end
        end
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    logic [DUR_BITS-1:0] max_dur;
    max_dur = '1;
    rst = 1'b1;
    push = 1'b0;
    item = '0;
    live_timers = 0;
    usec_now = '0;
    foreach (tmr_used[i]) begin
      tmr_used[i] = 1'b0;
      tmr_active[i] = 1'b0;
      tmr_periodic[i] = 1'b0;
    end
    send_idle_pct = 10;
    recv_idle_pct = 71;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: empty tick, creates, failures, clamping, restart, delete
    send_req(mk_req(REQ_TICK, 0, 0), 1'b1, mk_res(KIND_IDLE, 0, 1'b0, 1'b0, 1'b1));
    send_req(mk_req(REQ_CREATE, 0, 0), 1'b1, mk_res(KIND_ACK, 0, 1'b0, 1'b0, 1'b1));
    send_req(mk_req(REQ_CREATE, 31, max_dur), 1'b1, mk_res(KIND_ACK, 1, 1'b0, 1'b0, 1'b1));
    send_req(mk_req(REQ_QUERY, 31, 0), 1'b1, mk_res(KIND_ACK, 31, 1'b1, 1'b0, 1'b1));
    send_req(mk_req(REQ_BAD, 5, max_dur), 1'b1, mk_res(KIND_ACK, 5, 1'b1, 1'b0, 1'b1));
    send_req(mk_req(REQ_ONCE, 0, 0));
    send_req(mk_req(REQ_PER, 1, 0));
    send_req(mk_req(REQ_TICK, 0, 0));
    send_req(mk_req(REQ_TICK, 0, 0));
    send_req(mk_req(REQ_QUERY, 0, 0));
    send_req(mk_req(REQ_QUERY, 1, 0));
    send_req(mk_req(REQ_ONCE, 1, max_dur));
    send_req(mk_req(REQ_STOP, 1, 0));
    send_req(mk_req(REQ_CREATE, 0, 0));
    send_req(mk_req(REQ_PER, 2, 3));
    send_req(mk_req(REQ_ONCE, 0, 2));
    repeat (3) send_req(mk_req(REQ_TICK, 0, 0));
    send_req(mk_req(REQ_DELETE, 0, 0));
    send_req(mk_req(REQ_DELETE, 0, 0), 1'b1, mk_res(KIND_ACK, 0, 1'b1, 1'b0, 1'b1));
    send_req(mk_req(REQ_STOP, 31, 0), 1'b1, mk_res(KIND_ACK, 31, 1'b1, 1'b0, 1'b1));
    send_req(mk_req(REQ_ONCE, 20, 5), 1'b1, mk_res(KIND_ACK, 20, 1'b1, 1'b0, 1'b1));
    send_req(mk_req(REQ_CREATE, 0, 0));
    send_req(mk_req(REQ_TICK, 0, 0));

    // random: three idling phases, the second opens by filling the table
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_idle_pct = 71;
        recv_idle_pct = 10;
        repeat (TIMERS + 1) send_req(mk_req(REQ_CREATE, $urandom_range(31), 0));
        for (int k = 0; k < 8; k++)
          send_req(mk_req(REQ_PER, k, DUR_BITS'($urandom_range(1))));
        send_req(mk_req(REQ_TICK, 0, 0));
      end else if (ph == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      repeat (15) send_req(rand_req());
    end
    push <= 1'b0;

    // drain
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_beats.size() == 0)
      $display("PASS deadline_timer_table");
    else
      $display("FAIL deadline_timer_table");
    $finish;
  end

endmodule
